// File: rtl/lbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbu_pkg;

  localparam int BUFFER_BYTES_DEF   = 2048;
  localparam int MAX_FIELD_BITS_DEF = 64;

  localparam int MODE_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int REM_W   = 15;
  localparam int HEAD_W  = 15;
  localparam int OFF_W   = 3;
  localparam int TAKE_W  = 4;

  localparam logic [HEAD_W-1:0] HEAD_LIMIT = 15'h7FFF;
  localparam logic [TAKE_W-1:0] BYTE_BITS  = 4'd8;

  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [OFF_W-1:0]  off;
    logic [TAKE_W-1:0] take;
    logic [HEAD_W-1:0] head;
  } ext_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] field_byte;
    logic [HEAD_W-1:0] head_next;
    logic [REM_W-1:0]  rem;
  } ext_rsp_t;

  function automatic logic [BYTE_W-1:0] byte_mask(input logic [TAKE_W-1:0] take);
    logic [15:0] wide;
    wide = 16'h00FF >> (BYTE_BITS - take);
    return wide[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/lbu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lbu_req_if;
  logic                           valid;
  logic                           ready;
  logic [lbu_pkg::MODE_W-1:0]     mode;
  logic [lbu_pkg::BYTE_W-1:0]     load_byte;
  logic [lbu_pkg::COUNT_W-1:0]    bit_count;

  modport source (output valid, output mode, output load_byte, output bit_count,
                  input ready);
  modport sink (input valid, input mode, input load_byte, input bit_count,
                output ready);
endinterface

`default_nettype wire

// File: rtl/lbu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lbu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lbu_pkg::BYTE_W-1:0]    field_byte;
  logic                          last;
  logic [lbu_pkg::REM_W-1:0]     remaining_bits;
  logic                          overrun;

  modport source (output valid, output field_byte, output last,
                  output remaining_bits, output overrun, input ready);
  modport sink (input valid, input field_byte, input last,
                input remaining_bits, input overrun, output ready);
endinterface

`default_nettype wire

// File: rtl/lsb_first_bit_unpacker.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit stream reader that returns fields least significant bit first.
// Words arrive on req. A begin word empties the buffer and returns the read
// head to zero, a load word appends one byte, and a read word asks for a
// field of bit_count bits, clamped to MAX_FIELD_BITS. Begin, load and unused
// words, and reads of zero bits, produce nothing.
// A read produces ceil(n/8) words on rsp, low byte first, with the final one
// masked to its leftover bits and marked last. Each word also carries the
// unread bit count and an overrun flag when the field runs past loaded data.
// The first result word is formed in ST_FORM after the ST_HI fetch state and
// is then registered; the rest follow one per cycle while rsp is not stalled,
// and req stays not ready until the last is formed. ST_HI primes the single
// read port of the byte store, which feeds one shared shift and mask unit.
// While rsp is stalled, the last result is held in its output register and
// the sequencer waits; a new word is still taken once the read has finished.
// Synchronous reset empties the buffer, clears the head and drops rsp.valid.
module lsb_first_bit_unpacker #(
  parameter int BUFFER_BYTES   = lbu_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = lbu_pkg::MAX_FIELD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lbu_req_if.sink  req,
  lbu_rsp_if.source rsp
);

  localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W  = $clog2(BUFFER_BYTES);
  localparam int AVAIL_W = CNT_W + 3;
  localparam int IDX_W   = lbu_pkg::HEAD_W - 3 + 1;
  localparam int IC_W    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int OVR_W   = ((AVAIL_W > lbu_pkg::HEAD_W) ? AVAIL_W : lbu_pkg::HEAD_W) + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HI   = 2'd1;
  localparam logic [1:0] ST_FORM = 2'd2;

  logic [1:0]                        state;
  logic [CNT_W-1:0]                  loaded;
  logic [lbu_pkg::HEAD_W-1:0]        head;
  logic [lbu_pkg::COUNT_W-1:0]       left;
  logic                              ovr;
  logic [lbu_pkg::BYTE_W-1:0]        lo;
  logic [IDX_W-1:0]                  idx;
  logic                              out_valid;
  logic [lbu_pkg::BYTE_W-1:0]        out_byte;
  logic                              out_last;
  logic [lbu_pkg::REM_W-1:0]         out_rem;
  logic                              out_ovr;

  logic                              accept;
  logic                              emit;
  logic                              more;
  logic                              buf_full;
  logic [lbu_pkg::COUNT_W-1:0]       n_clamp;
  logic                              ovr_now;
  logic [AVAIL_W-1:0]                avail;
  logic [IDX_W-1:0]                  head_idx;
  logic [IDX_W-1:0]                  hi_idx;
  logic                              lo_ok;
  logic                              hi_ok;
  logic [lbu_pkg::BYTE_W-1:0]        rdata;
  logic [lbu_pkg::BYTE_W-1:0]        hi_m;
  logic [ADDR_W-1:0]                 raddr;
  logic [lbu_pkg::TAKE_W-1:0]        take;
  lbu_pkg::ext_req_t                 ext_req;
  lbu_pkg::ext_rsp_t                 ext_rsp;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign emit      = (state == ST_FORM) && (!out_valid || rsp.ready);
  assign more      = (left > lbu_pkg::COUNT_W'(8));
  assign buf_full  = (loaded >= CNT_W'(BUFFER_BYTES));
  assign avail     = {loaded, 3'b000};
  assign head_idx  = IDX_W'(head[lbu_pkg::HEAD_W-1:3]);
  assign hi_idx    = idx + IDX_W'(1);
  assign lo_ok     = IC_W'(idx) < IC_W'(loaded);
  assign hi_ok     = IC_W'(hi_idx) < IC_W'(loaded);
  assign hi_m      = hi_ok ? rdata : '0;
  assign take      = more ? lbu_pkg::BYTE_BITS : left[lbu_pkg::TAKE_W-1:0];

  always_comb begin
    if (req.bit_count > lbu_pkg::COUNT_W'(MAX_FIELD_BITS)) begin
      n_clamp = lbu_pkg::COUNT_W'(MAX_FIELD_BITS);
    end else begin
      n_clamp = req.bit_count;
    end
    ovr_now = (OVR_W'(head) + OVR_W'(n_clamp)) > OVR_W'(avail);
  end

  always_comb begin
    unique case (state)
      ST_IDLE: raddr = ADDR_W'(head_idx);
      ST_HI:   raddr = ADDR_W'(hi_idx);
      ST_FORM: raddr = emit ? ADDR_W'(idx + IDX_W'(2)) : ADDR_W'(hi_idx);
      default: raddr = ADDR_W'(head_idx);
    endcase
  end

  lbu_ram #(
    .WIDTH (lbu_pkg::BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (accept && (req.mode == lbu_pkg::MODE_LOAD) && !buf_full),
    .waddr (ADDR_W'(loaded)),
    .wdata (req.load_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ext_req.lo   = lo;
  assign ext_req.hi   = hi_m;
  assign ext_req.off  = head[2:0];
  assign ext_req.take = take;
  assign ext_req.head = head;

  lbu_extract #(
    .AVAIL_W (AVAIL_W)
  ) u_extract (
    .req   (ext_req),
    .avail (avail),
    .rsp   (ext_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      loaded <= '0;
      head   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.mode == lbu_pkg::MODE_BEGIN) begin
              loaded <= '0;
              head   <= '0;
            end else if (req.mode == lbu_pkg::MODE_LOAD) begin
              if (!buf_full) begin
                loaded <= loaded + CNT_W'(1);
              end
            end else if ((req.mode == lbu_pkg::MODE_READ) && (n_clamp != '0)) begin
              state <= ST_HI;
            end
          end
        end
        ST_HI: begin
          state <= ST_FORM;
        end
        ST_FORM: begin
          if (emit) begin
            head <= ext_rsp.head_next;
            if (!more) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left <= n_clamp;
      ovr  <= ovr_now;
      idx  <= head_idx;
    end
    if (state == ST_HI) begin
      lo <= lo_ok ? rdata : '0;
    end
    if (emit) begin
      left     <= left - lbu_pkg::COUNT_W'(take);
      lo       <= hi_m;
      idx      <= hi_idx;
      out_byte <= ext_rsp.field_byte;
      out_last <= !more;
      out_rem  <= ext_rsp.rem;
      out_ovr  <= ovr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.field_byte     = out_byte;
  assign rsp.last           = out_last;
  assign rsp.remaining_bits = out_rem;
  assign rsp.overrun        = out_ovr;

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CNT_W'(BUFFER_BYTES))
    else $error("loaded byte count exceeds the buffer size");

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode == lbu_pkg::MODE_READ) && (req.bit_count != '0))
      |=> (state == ST_HI))
    else $error("read word did not start the fetch sequence");

  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    (emit && more) |=> ((state == ST_FORM) && out_valid && !out_last))
    else $error("field ended before all of its bytes were produced");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && !more) |=> ((state == ST_IDLE) && out_valid && out_last))
    else $error("final field byte did not return the sequencer to idle");

endmodule

`default_nettype wire

// File: rtl/lbu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/lbu_extract.sv
`timescale 1ns / 1ps
`default_nettype none

module lbu_extract #(
  parameter int AVAIL_W = 15
) (
  input  wire lbu_pkg::ext_req_t    req,
  input  wire logic [AVAIL_W-1:0]   avail,
  output lbu_pkg::ext_rsp_t         rsp
);

  localparam int CW = (AVAIL_W > lbu_pkg::HEAD_W) ? AVAIL_W : lbu_pkg::HEAD_W;

  logic [2*lbu_pkg::BYTE_W-1:0] pair;
  logic [2*lbu_pkg::BYTE_W-1:0] shifted;
  logic [lbu_pkg::HEAD_W:0]     sum;
  logic [lbu_pkg::HEAD_W-1:0]   head_next;
  logic [CW-1:0]                avail_x;
  logic [CW-1:0]                head_x;
  logic [CW-1:0]                rem_full;

  always_comb begin
    pair    = {req.hi, req.lo};
    shifted = pair >> req.off;
    sum     = {1'b0, req.head} + (lbu_pkg::HEAD_W + 1)'(req.take);
    if (sum > {1'b0, lbu_pkg::HEAD_LIMIT}) begin
      head_next = lbu_pkg::HEAD_LIMIT;
    end else begin
      head_next = sum[lbu_pkg::HEAD_W-1:0];
    end
    avail_x = CW'(avail);
    head_x  = CW'(head_next);
    if (avail_x > head_x) begin
      rem_full = avail_x - head_x;
    end else begin
      rem_full = '0;
    end
    rsp.field_byte = shifted[lbu_pkg::BYTE_W-1:0] & lbu_pkg::byte_mask(req.take);
    rsp.head_next  = head_next;
    rsp.rem        = lbu_pkg::REM_W'(rem_full);
  end

endmodule

`default_nettype wire

// File: tb/sv/unpacker_checker.sv
`timescale 1ns / 1ps

module unpacker_checker
  import lbu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lbu_req_if   req,
  lbu_rsp_if   rsp,
  output int   mismatches,
  output int   fields_owed
);

  typedef struct packed {
    logic [BYTE_W-1:0] field_byte;
    logic              last;
    logic [REM_W-1:0]  remaining_bits;
    logic              overrun;
  } field_word_t;

  logic [BYTE_W-1:0] packet_bytes [BUFFER_BYTES_DEF];
  int unsigned       stored_bytes;
  int unsigned       bit_head;
  field_word_t       owed_words [$];

  initial begin
    mismatches  = 0;
    fields_owed = 0;
  end

  task automatic note_failure(input string msg);
    if (mismatches < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Splits one field read into its result words, low byte first.
  task automatic predict_field(input int unsigned asked);
    int unsigned width;
    int unsigned avail;
    int unsigned left;
    int unsigned take;
    int unsigned pos;
    int unsigned i;
    logic        beyond;
    field_word_t w;
    width  = (asked > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : asked;
    avail  = stored_bytes * 8;
    beyond = (bit_head + width > avail);
    left   = width;
    while (left > 0) begin
      take = (left > 8) ? 8 : left;
      w    = '0;
      for (i = 0; i < take; i++) begin
        pos = bit_head + i;
        if (pos < avail) begin
          w.field_byte[i] = packet_bytes[pos >> 3][pos & 7];
        end
      end
      bit_head = (bit_head + take > int'(HEAD_LIMIT)) ? int'(HEAD_LIMIT) : bit_head + take;
      left -= take;
      w.last           = (left == 0);
      w.remaining_bits = (avail > bit_head) ? REM_W'(avail - bit_head) : '0;
      w.overrun        = beyond;
      owed_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    field_word_t want;
    field_word_t got;
    if (rst) begin
      stored_bytes = 0;
      bit_head     = 0;
      owed_words.delete();
    end else begin
      if (req.valid && req.ready) begin
        case (req.mode)
          MODE_BEGIN: begin
            stored_bytes = 0;
            bit_head     = 0;
          end
          MODE_LOAD: begin
            if (stored_bytes < BUFFER_BYTES_DEF) begin
              packet_bytes[stored_bytes] = req.load_byte;
              stored_bytes++;
            end
          end
          MODE_READ: begin
            if (req.bit_count != 0) begin
              predict_field(req.bit_count);
            end
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got.field_byte     = rsp.field_byte;
        got.last           = rsp.last;
        got.remaining_bits = rsp.remaining_bits;
        got.overrun        = rsp.overrun;
        if (owed_words.size() == 0) begin
          note_failure($sformatf("unexpected word: byte %02h last %0d rem %0d ovr %0d",
                                 got.field_byte, got.last, got.remaining_bits, got.overrun));
        end else begin
          want = owed_words.pop_front();
          if (got.field_byte !== want.field_byte || got.last !== want.last ||
              got.remaining_bits !== want.remaining_bits || got.overrun !== want.overrun) begin
            note_failure($sformatf({"mismatch: expected byte %02h last %0d rem %0d ovr %0d,",
                                    " got byte %02h last %0d rem %0d ovr %0d"},
                                   want.field_byte, want.last, want.remaining_bits,
                                   want.overrun, got.field_byte, got.last,
                                   got.remaining_bits, got.overrun));
          end
        end
      end
    end
    fields_owed = owed_words.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lbu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 150;
  localparam int FILL_BYTES   = 40;
  localparam int FILL_READS   = 12;

  logic clk;
  logic rst;
  logic calm;
  int   mismatches;
  int   fields_owed;
  int   cycles;
  int   words_sent;

  lbu_req_if req ();
  lbu_rsp_if rsp ();

  lsb_first_bit_unpacker i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  unpacker_checker i_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .fields_owed(fields_owed)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                           input logic [COUNT_W-1:0] count);
    while (!calm && $urandom_range(0, 99) < 17) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.load_byte <= data;
    req.bit_count <= count;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic read_field(input logic [COUNT_W-1:0] count);
    send_word(MODE_READ, BYTE_W'($urandom), count);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (fields_owed != 0) begin
      @(negedge clk);
    end
  endtask

  // A begin, a short burst of loads, then reads mixed with late loads and noise.
  task automatic random_packet();
    int unsigned loads;
    int unsigned reads;
    int unsigned pick;
    int unsigned i;
    send_word(MODE_BEGIN, BYTE_W'($urandom), COUNT_W'($urandom));
    loads = $urandom_range(1, 12);
    for (i = 0; i < loads; i++) begin
      send_word(MODE_LOAD, BYTE_W'($urandom), COUNT_W'($urandom));
    end
    reads = $urandom_range(1, 7);
    for (i = 0; i < reads; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        read_field(COUNT_W'($urandom_range(1, 16)));
      end else if (pick < 72) begin
        read_field(COUNT_W'($urandom_range(17, 64)));
      end else if (pick < 80) begin
        read_field(COUNT_W'($urandom_range(65, 127)));
      end else if (pick < 85) begin
        read_field('0);
      end else if (pick < 94) begin
        send_word(MODE_LOAD, BYTE_W'($urandom), COUNT_W'($urandom));
      end else begin
        send_word(MODE_SPARE, BYTE_W'($urandom), COUNT_W'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned i;
    int unsigned stop_at;
    rst           = 1'b1;
    calm          = 1'b0;
    cycles        = 0;
    words_sent    = 0;
    req.valid     = 1'b0;
    req.mode      = MODE_BEGIN;
    req.load_byte = '0;
    req.bit_count = '0;
    rsp.ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    read_field(7'd8);
    send_word(MODE_BEGIN, 8'h00, 7'd0);
    send_word(MODE_LOAD, 8'h00, 7'd0);
    send_word(MODE_LOAD, 8'hFF, 7'd0);
    send_word(MODE_LOAD, 8'hA5, 7'd0);
    send_word(MODE_LOAD, 8'h5A, 7'd0);
    send_word(MODE_LOAD, 8'h01, 7'd0);
    send_word(MODE_LOAD, 8'h80, 7'd0);
    read_field(7'd1);
    read_field(7'd7);
    read_field(7'd0);
    read_field(7'd9);
    read_field(7'd3);
    send_word(MODE_SPARE, 8'hFF, 7'h7F);
    read_field(7'd64);
    read_field(7'd127);
    read_field(7'd65);
    send_word(MODE_BEGIN, 8'hFF, 7'h7F);
    send_word(MODE_LOAD, 8'hC3, 7'h7F);
    read_field(7'd8);

    wait_drained();

    // Load a longer packet without idling, then read well past its end.
    calm = 1'b1;
    send_word(MODE_BEGIN, 8'h00, 7'd0);
    for (i = 0; i < FILL_BYTES; i++) begin
      send_word(MODE_LOAD, BYTE_W'($urandom), COUNT_W'($urandom));
    end
    for (i = 0; i < FILL_READS; i++) begin
      if (i == 6) begin
        calm = 1'b0;
      end
      read_field(7'd64);
    end
    read_field(7'd1);
    read_field(7'd13);

    wait_drained();

    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      random_packet();
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lbu_pkg.sv
rtl/lbu_req_if.sv
rtl/lbu_rsp_if.sv
rtl/lbu_ram.sv
rtl/lbu_extract.sv
rtl/lsb_first_bit_unpacker.sv
tb/sv/unpacker_checker.sv
tb/sv/tb_top.sv
